[rtl/core/b64d_pkg.sv]
// b64d_pkg: shared types, constants and the character classifier for the
// base64 stream decoder. No dependencies.
package b64d_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] PadCode   = 8'h3D;
  localparam logic [7:0] UpperLo   = 8'h41;
  localparam logic [7:0] UpperHi   = 8'h5A;
  localparam logic [7:0] LowerLo   = 8'h61;
  localparam logic [7:0] LowerHi   = 8'h7A;
  localparam logic [7:0] LowerOff  = 8'h47;
  localparam logic [7:0] DigitLo   = 8'h30;
  localparam logic [7:0] DigitHi   = 8'h39;
  localparam logic [7:0] PlusCode  = 8'h2B;
  localparam logic [7:0] SlashCode = 8'h2F;
  localparam logic [5:0] PlusVal   = 6'h3E;
  localparam logic [5:0] SlashVal  = 6'h3F;

  // byte counts of a decoded group
  localparam logic [1:0] OneByte   = 2'd1;
  localparam logic [1:0] TwoBytes  = 2'd2;
  localparam logic [1:0] ThreeBytes = 2'd3;

  // one queued group: bytes left-aligned in bits
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  nbytes;
    logic        last;
    logic        err;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // returns {invalid, sextet}
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'd0;
      if (c >= UpperLo && c <= UpperHi) begin
        t = c - UpperLo;
        sextet_of = {1'b0, t[5:0]};
      end else if (c >= LowerLo && c <= LowerHi) begin
        t = c - LowerOff;
        sextet_of = {1'b0, t[5:0]};
      end else if (c >= DigitLo && c <= DigitHi) begin
        t = c + 8'd4;
        sextet_of = {1'b0, t[5:0]};
      end else if (c == PlusCode) begin
        sextet_of = {1'b0, PlusVal};
      end else if (c == SlashCode) begin
        sextet_of = {1'b0, SlashVal};
      end else begin
        sextet_of = {1'b1, t[5:0]};
      end
    end
  endfunction

endpackage

[rtl/core/b64d_front.sv]
// b64d_front: takes characters, tracks group position and pad/discard state,
// and pushes one decoded group command per result event. Uses b64d_pkg.
module b64d_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         char_code_i,
  input  logic               last_char_i,
  output logic               q_push_o,
  output b64d_pkg::cmd_t     q_cmd_o
);

  logic [1:0]  pos_q, pos_d;
  logic [17:0] acc_q, acc_d;
  logic        pad_q, pad_d;
  logic        disc_q, disc_d;
  logic        emit;
  b64d_pkg::cmd_t cmd;
  logic [6:0]  sx;

  always_comb begin
    pos_d  = pos_q;
    acc_d  = acc_q;
    pad_d  = pad_q;
    disc_d = disc_q;
    emit   = 1'b0;
    cmd    = '{bits: 24'd0, nbytes: b64d_pkg::OneByte, last: 1'b1, err: 1'b1};
    sx     = b64d_pkg::sextet_of(char_code_i);

    if (disc_q) begin
      if (last_char_i) disc_d = 1'b0;
    end else if (pad_q) begin
      pos_d = 2'd0;
      acc_d = 18'd0;
      pad_d = 1'b0;
      emit  = 1'b1;
      if (last_char_i) begin
        cmd.bits = {acc_q[11:4], 16'd0};
        cmd.err  = 1'b0;
      end else begin
        disc_d = 1'b1;
      end
    end else if (char_code_i == b64d_pkg::PadCode) begin
      if (pos_q == 2'd2 && !last_char_i) begin
        pad_d = 1'b1;
      end else begin
        pos_d = 2'd0;
        acc_d = 18'd0;
        emit  = 1'b1;
        if (pos_q == 2'd3 && last_char_i) begin
          cmd.bits   = {acc_q, 6'd0};
          cmd.nbytes = b64d_pkg::TwoBytes;
          cmd.err    = 1'b0;
        end else begin
          disc_d = !last_char_i;
        end
      end
    end else if (sx[6]) begin
      pos_d  = 2'd0;
      acc_d  = 18'd0;
      emit   = 1'b1;
      disc_d = !last_char_i;
    end else if (pos_q != 2'd3) begin
      if (last_char_i) begin
        // message ends inside a group
        pos_d = 2'd0;
        acc_d = 18'd0;
        emit  = 1'b1;
      end else begin
        acc_d = {acc_q[11:0], sx[5:0]};
        pos_d = pos_q + 2'd1;
      end
    end else begin
      pos_d      = 2'd0;
      acc_d      = 18'd0;
      emit       = 1'b1;
      cmd.bits   = {acc_q, sx[5:0]};
      cmd.nbytes = b64d_pkg::ThreeBytes;
      cmd.last   = last_char_i;
      cmd.err    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 2'd0;
      acc_q  <= 18'd0;
      pad_q  <= 1'b0;
      disc_q <= 1'b0;
    end else if (accept_i) begin
      pos_q  <= pos_d;
      acc_q  <= acc_d;
      pad_q  <= pad_d;
      disc_q <= disc_d;
    end
  end

  assign q_push_o = accept_i && emit;
  assign q_cmd_o  = cmd;

endmodule

[rtl/core/b64d_queue.sv]
// b64d_queue: small FIFO of group commands between front and back.
// Uses b64d_pkg.
module b64d_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  b64d_pkg::cmd_t     cmd_i,
  input  logic               pop_i,
  output b64d_pkg::cmd_t     cmd_o,
  output b64d_pkg::qstat_t   stat_o
);

  b64d_pkg::cmd_t mem_q [b64d_pkg::QDepth];
  logic [b64d_pkg::QPtrW-1:0] wr_q, rd_q;
  logic [b64d_pkg::QCntW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + b64d_pkg::QPtrW'(1);
      if (pop_i)  rd_q <= rd_q + b64d_pkg::QPtrW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + b64d_pkg::QCntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - b64d_pkg::QCntW'(1);
    end
  end

  assign cmd_o        = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == b64d_pkg::QCntW'(b64d_pkg::QDepth));
  assign stat_o.empty = (cnt_q == '0);

endmodule

[rtl/core/b64d_back.sv]
// b64d_back: unpacks queued group commands into single output words held
// in an output register. Uses b64d_pkg.
module b64d_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  b64d_pkg::cmd_t     q_cmd_i,
  input  b64d_pkg::qstat_t   q_stat_i,
  output logic               q_pop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output logic [7:0]         data_byte_o,
  output logic               last_byte_o,
  output logic               error_o
);

  b64d_pkg::cmd_t work_q;
  logic           work_vld_q;
  logic [1:0]     idx_q;
  logic           out_vld_q;
  logic [7:0]     data_q;
  logic           last_q, err_q;
  logic           out_free, final_byte, take_byte, work_free;
  logic [7:0]     sel_byte;

  assign out_free   = !out_vld_q || pop_i;
  assign final_byte = (idx_q == work_q.nbytes - 2'd1);
  assign take_byte  = out_free && work_vld_q;
  assign work_free  = !work_vld_q || (take_byte && final_byte);
  assign q_pop_o    = work_free && !q_stat_i.empty;

  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = work_q.bits[23:16];
      2'd1:    sel_byte = work_q.bits[15:8];
      default: sel_byte = work_q.bits[7:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_vld_q <= 1'b0;
      idx_q      <= 2'd0;
      out_vld_q  <= 1'b0;
    end else begin
      if (q_pop_o) begin
        work_vld_q <= 1'b1;
        idx_q      <= 2'd0;
      end else if (work_free) begin
        work_vld_q <= 1'b0;
      end else if (take_byte) begin
        idx_q <= idx_q + 2'd1;
      end
      if (take_byte)   out_vld_q <= 1'b1;
      else if (pop_i)  out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) work_q <= q_cmd_i;
    if (take_byte) begin
      data_q <= sel_byte;
      last_q <= work_q.last && final_byte;
      err_q  <= work_q.err;
    end
  end

  assign empty_o     = !out_vld_q;
  assign data_byte_o = data_q;
  assign last_byte_o = last_q;
  assign error_o     = err_q;

endmodule

[rtl/core/base64_stream_decoder.sv]
// base64_stream_decoder: top level, front classifier, command queue and
// byte unpacker. Uses b64d_pkg, b64d_front, b64d_queue, b64d_back.
//
// Usage:
//   Input channel: a character word is taken at a clock edge with push high
//   and full low; last_char_i marks the final character of a message.
//   Output channel: while empty is low the oldest byte word sits on
//   data_byte_o/last_byte_o/error_o and is taken at an edge with pop high.
//   Every fourth character (or a pad/error event) queues one group command;
//   the back end unpacks it at one byte per cycle while the output register is
//   empty or pop is high. A byte passes from the edge that takes the character
//   completing its group through the queue (written at that edge), the
//   unpacker's work register and then the output register, in that order.
//   Throughput: one character per cycle; a valid group gives three bytes per
//   four characters, an error at most one word per character, and the output
//   register drains one word per cycle, so with pop held high input never stalls.
//   full rises only when the 4-entry command queue is full, i.e. when the
//   receiver has stalled long enough to back up several groups.
//   An error gives a single word with error_o and last_byte_o set; bytes
//   already sent from that message stand and the rest of it is dropped.
//   Reset clears group state, queue and output register; no clearing pass.
module base64_stream_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] data_byte_o,
  output logic       last_byte_o,
  output logic       error_o
);

  b64d_pkg::cmd_t   push_cmd, head_cmd;
  b64d_pkg::qstat_t q_stat;
  logic             accept, q_push, q_pop;

  assign full   = q_stat.full;
  assign accept = push && !q_stat.full;

  b64d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .q_push_o    (q_push),
    .q_cmd_o     (push_cmd)
  );

  b64d_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (push_cmd),
    .pop_i  (q_pop),
    .cmd_o  (head_cmd),
    .stat_o (q_stat)
  );

  b64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_cmd_i     (head_cmd),
    .q_stat_i    (q_stat),
    .q_pop_o     (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .data_byte_o (data_byte_o),
    .last_byte_o (last_byte_o),
    .error_o     (error_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("command pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("command popped from empty queue");

  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && error_o) |-> (data_byte_o == 8'd0 && last_byte_o))
    else $error("error word not zero or not marked last");

  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && !q_pop) |=> !q_stat.empty)
    else $error("queue empty after net push");

endmodule
